>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ACPP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ACPP_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("illegal condition");
`else
`define ACPP_ASSERT(lbl, clk, rst, prop)
`define ACPP_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> hw/rtl/acpp_pkg.sv
// ----------------------------------------------------------------------------
// ASCII command packet parser package
// Field widths, parser modes, result kinds and level scaling constants.
// ----------------------------------------------------------------------------
package acpp_pkg;

   localparam int BYTE_W  = 8;
   localparam int DIGIT_W = 4;
   localparam int FIELD_W = 7;
   localparam int KIND_W  = 3;
   localparam int MODE_W  = 3;
   localparam int CNT_W   = 4;

   localparam int TIME_DIGITS = 12;
   localparam logic [CNT_W-1:0] TIME_NEED  = CNT_W'(TIME_DIGITS);
   localparam logic [CNT_W-1:0] ALARM_NEED = CNT_W'(11);
   localparam int DAYS = 7;

   localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LEVEL   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TIME    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ALARM   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DISCARD = 3'd4;

   localparam logic [KIND_W-1:0] KIND_LEVEL     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TIME      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ALARM     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_TIME  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BAD_ALARM = 3'd4;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 3'd5;

   localparam logic [BYTE_W-1:0] CHAR_H    = 8'h48;
   localparam logic [BYTE_W-1:0] CHAR_T    = 8'h54;
   localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

   // level value v = (c1*10 + c2 - 528) mod 256, accepted when v <= LEVEL_MAX
   localparam logic [BYTE_W-1:0] LEVEL_OFS = 8'd16;
   localparam logic [BYTE_W-1:0] LEVEL_MAX = 8'd100;
   localparam logic [FIELD_W-1:0] MINBRIGHT = 7'd124;

   // ceil(v*12121/10000) = ((v*12121 + 9999) * RECIP) >> RECIP_SH, exact for v <= 127
   localparam int RECIP_SH = 36;
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + 64'd9999) / 64'd10000;
   localparam longint unsigned LVL_MUL  = 64'd12121 * RECIP;
   localparam longint unsigned LVL_BIAS = 64'd9999 * RECIP;
   localparam int PROD_W = 45;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] level;
      logic [FIELD_W-1:0] year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day_of_month;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
      logic [FIELD_W-1:0] weekday_mask;
   } rec_type;

   function automatic logic [FIELD_W-1:0] pair(input logic [DIGIT_W-1:0] hi,
                                               input logic [DIGIT_W-1:0] lo);
      pair = FIELD_W'(hi) * FIELD_W'(10) + FIELD_W'(lo);
   endfunction

endpackage

>>> hw/rtl/ascii_command_packet_parser.sv
// ----------------------------------------------------------------------------
// ASCII command packet parser
// Parses level (H), time (T) and alarm (A) packets from a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per clock while req_tready is high. For the byte that
// completes a packet, the parse stage registers the decoded fields, then the
// second stage scales the dimmer level through one constant multiply and
// registers the beat. req_tready drops only when both stages hold results and
// rsp_tready is low. Bytes that close no packet produce no beat; after any
// result the rest of the burst is dropped until a beat with req_tlast.
`include "assert_macros.svh"

module ascii_command_packet_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tlast,   // burst_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // level, year, month, day_of_month, hour,
                                    // minute, second, weekday_mask (7 bits each)
   output logic [2:0]  rsp_tuser    // kind
);

   logic [acpp_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [acpp_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [acpp_pkg::BYTE_W-1:0]  fc_ff, fc_in;
   logic [acpp_pkg::DIGIT_W-1:0] store_ff [acpp_pkg::TIME_DIGITS];

   logic                s1_vld_ff, s1_vld_in;
   acpp_pkg::rec_type   s1_rec_ff, s1_rec_in;
   logic                rsp_vld_ff, rsp_vld_in;
   acpp_pkg::rec_type   rsp_rec_ff, rsp_rec_in;

   logic                          req_acc, out_free, s1_adv, hit, dig_we, is_digit;
   logic [acpp_pkg::DIGIT_W-1:0]  dval;
   logic [acpp_pkg::BYTE_W-1:0]   v8;
   logic [acpp_pkg::CNT_W-1:0]    cnt_inc;
   logic [acpp_pkg::PROD_W-1:0]   prod;
   logic [acpp_pkg::FIELD_W-1:0]  scaled;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign s1_adv     = s1_vld_ff && out_free;
   assign req_tready = !s1_vld_ff || out_free;
   assign req_acc    = req_tvalid && req_tready;

   assign is_digit = (req_tdata >= acpp_pkg::CHAR_ZERO) && (req_tdata <= acpp_pkg::CHAR_NINE);
   assign dval     = acpp_pkg::DIGIT_W'(req_tdata - acpp_pkg::CHAR_ZERO);
   assign v8       = acpp_pkg::BYTE_W'(fc_ff * 8'd10) + req_tdata - acpp_pkg::LEVEL_OFS;
   assign cnt_inc  = cnt_ff + 4'd1;

   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      fc_in     = fc_ff;
      hit       = 1'b0;
      dig_we    = 1'b0;
      s1_rec_in = '0;
      case (mode_ff)
         acpp_pkg::MODE_WAIT: begin
            cnt_in = '0;
            if (req_tdata == acpp_pkg::CHAR_H) begin
               mode_in = acpp_pkg::MODE_LEVEL;
            end else if (req_tdata == acpp_pkg::CHAR_T) begin
               mode_in = acpp_pkg::MODE_TIME;
            end else if (req_tdata == acpp_pkg::CHAR_A) begin
               mode_in = acpp_pkg::MODE_ALARM;
            end else begin
               hit            = 1'b1;
               s1_rec_in.kind = acpp_pkg::KIND_UNKNOWN;
               mode_in        = acpp_pkg::MODE_DISCARD;
            end
         end
         acpp_pkg::MODE_LEVEL: begin
            if (cnt_ff == '0) begin
               fc_in  = req_tdata;
               cnt_in = 4'd1;
            end else begin
               if (v8 <= acpp_pkg::LEVEL_MAX) begin
                  hit             = 1'b1;
                  s1_rec_in.kind  = acpp_pkg::KIND_LEVEL;
                  s1_rec_in.level = v8[acpp_pkg::FIELD_W-1:0];
               end
               mode_in = acpp_pkg::MODE_DISCARD;
            end
         end
         acpp_pkg::MODE_TIME, acpp_pkg::MODE_ALARM: begin
            if (is_digit) begin
               dig_we = cnt_ff < acpp_pkg::TIME_NEED;
               cnt_in = cnt_inc;
               if (mode_ff == acpp_pkg::MODE_TIME && cnt_inc >= acpp_pkg::TIME_NEED) begin
                  hit                    = 1'b1;
                  s1_rec_in.kind         = acpp_pkg::KIND_TIME;
                  s1_rec_in.year         = acpp_pkg::pair(store_ff[0], store_ff[1]);
                  s1_rec_in.month        = acpp_pkg::pair(store_ff[2], store_ff[3]);
                  s1_rec_in.day_of_month = acpp_pkg::pair(store_ff[4], store_ff[5]);
                  s1_rec_in.hour         = acpp_pkg::pair(store_ff[6], store_ff[7]);
                  s1_rec_in.minute       = acpp_pkg::pair(store_ff[8], store_ff[9]);
                  s1_rec_in.second       = acpp_pkg::pair(store_ff[10], dval);
                  mode_in                = acpp_pkg::MODE_DISCARD;
               end else if (mode_ff == acpp_pkg::MODE_ALARM &&
                            cnt_inc >= acpp_pkg::ALARM_NEED) begin
                  hit              = 1'b1;
                  s1_rec_in.kind   = acpp_pkg::KIND_ALARM;
                  for (int i = 0; i < acpp_pkg::DAYS; i++) begin
                     s1_rec_in.weekday_mask[i] = store_ff[i] != '0;
                  end
                  s1_rec_in.hour   = acpp_pkg::pair(store_ff[7], store_ff[8]);
                  s1_rec_in.minute = acpp_pkg::pair(store_ff[9], dval);
                  mode_in          = acpp_pkg::MODE_DISCARD;
               end
            end else begin
               hit            = 1'b1;
               s1_rec_in.kind = (mode_ff == acpp_pkg::MODE_TIME) ?
                                acpp_pkg::KIND_BAD_TIME : acpp_pkg::KIND_BAD_ALARM;
               mode_in        = acpp_pkg::MODE_DISCARD;
            end
         end
         default: begin
            mode_in = acpp_pkg::MODE_DISCARD;
         end
      endcase
      if (req_tlast) begin
         mode_in = acpp_pkg::MODE_WAIT;
         cnt_in  = '0;
      end
   end

   always_comb begin
      if (req_acc) begin
         s1_vld_in = hit;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end
   end

   // level = 124 - ceil(v * 1.2121)
   assign prod   = acpp_pkg::PROD_W'(s1_rec_ff.level) * acpp_pkg::PROD_W'(acpp_pkg::LVL_MUL)
                 + acpp_pkg::PROD_W'(acpp_pkg::LVL_BIAS);
   assign scaled = prod[acpp_pkg::RECIP_SH +: acpp_pkg::FIELD_W];

   always_comb begin
      rsp_rec_in = s1_rec_ff;
      if (s1_rec_ff.kind == acpp_pkg::KIND_LEVEL) begin
         rsp_rec_in.level = acpp_pkg::MINBRIGHT - scaled;
      end
      if (s1_adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= acpp_pkg::MODE_WAIT;
         cnt_ff     <= '0;
         fc_ff      <= '0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            mode_ff <= mode_in;
            cnt_ff  <= cnt_in;
            fc_ff   <= fc_in;
         end
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && dig_we) begin
         store_ff[cnt_ff] <= dval;
      end
      if (req_acc) begin
         s1_rec_ff <= s1_rec_in;
      end
      if (s1_adv) begin
         rsp_rec_ff <= rsp_rec_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_rec_ff.kind;
   assign rsp_tdata  = {rsp_rec_ff.weekday_mask, rsp_rec_ff.second, rsp_rec_ff.minute,
                        rsp_rec_ff.hour, rsp_rec_ff.day_of_month, rsp_rec_ff.month,
                        rsp_rec_ff.year, rsp_rec_ff.level};

   `ACPP_ASSERT(a_s1_hold, clock, reset, s1_vld_ff && !out_free |=> s1_vld_ff && $stable(s1_rec_ff))
   `ACPP_ASSERT(a_burst_end, clock, reset, req_acc && req_tlast |=> mode_ff == acpp_pkg::MODE_WAIT && cnt_ff == '0)
   `ACPP_NEVER(a_cnt_range, clock, reset, cnt_ff > acpp_pkg::TIME_NEED)
   `ACPP_NEVER(a_ready_empty, clock, reset, !req_tready && !s1_vld_ff)
   `ACPP_NEVER(a_kind_range, clock, reset, rsp_vld_ff && rsp_rec_ff.kind > acpp_pkg::KIND_UNKNOWN)

endmodule
